@@ hw/rtl/mac_frame_assembler_with_fcs_defines.svh @@
// Assertion macros shared by the frame assembler modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef MAC_FRAME_ASSEMBLER_WITH_FCS_DEFINES_SVH
`define MAC_FRAME_ASSEMBLER_WITH_FCS_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mfa_pkg.sv @@
`default_nettype none

package mfa_pkg;

    localparam int FRAME_MAX_DEFAULT = 127;
    localparam int QUEUE_DEPTH       = 2;

    // Header byte slots in transmit order: frame control (2), sequence
    // number (1), destination PAN (2), destination address (8), source
    // PAN (2), source address (8).
    localparam int HDR_SLOTS   = 23;
    localparam int SLOT_W      = 5;
    localparam int SLOT_FC     = 0;
    localparam int SLOT_DPAN   = 3;
    localparam int SLOT_DADDR  = 5;
    localparam int SLOT_SPAN   = 13;
    localparam int SLOT_SADDR  = 15;

    localparam logic [1:0]  MODE_NONE  = 2'd0;
    localparam logic [1:0]  MODE_SHORT = 2'd2;
    localparam logic [1:0]  MODE_EXT   = 2'd3;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [6:0]  FCS_BYTES  = 7'd2;

    typedef struct packed {
        logic                            is_hdr;
        logic                            too_long;
        logic                            fin;
        logic [HDR_SLOTS-1:0]            mask;
        logic [HDR_SLOTS-1:0][7:0]       bytes;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
        case (mode)
            MODE_SHORT: return 4'd2;
            MODE_EXT:   return 4'd8;
            default:    return 4'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mfa_ifs.sv @@
`default_nettype none

interface mfa_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] frame_control;
    logic [7:0]  sequence_number;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [15:0] source_pan;
    logic [63:0] source_address;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;

    modport source (
        output valid, kind, frame_control, sequence_number, dest_pan, dest_address,
               source_pan, source_address, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_control, sequence_number, dest_pan, dest_address,
               source_pan, source_address, payload_length, payload_byte,
        output ready
    );
endinterface

interface mfa_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;
    logic       too_long;
    logic [6:0] frame_length;

    modport source (
        output valid, frame_byte, last, too_long, frame_length,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last, too_long, frame_length,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/mfa_front.sv @@
`default_nettype none

// Accepts items, tracks frame bookkeeping and turns each item that
// produces output into a job for the back end.
module mfa_front #(
    parameter int MAX_FRAME_BYTES = mfa_pkg::FRAME_MAX_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mfa_item_if.sink         item,
    input  wire logic        full,
    output logic             push,
    output mfa_pkg::job_t    job
);

    logic [6:0] remaining_reg, remaining_next;
    logic       open_reg, open_next;
    logic       drop_reg, drop_next;

    logic       accept;
    logic [1:0] dmode, smode;
    logic       send_span;
    logic [4:0] hlen;
    logic [7:0] total;
    logic       oversize;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;

    assign dmode     = item.frame_control[11:10];
    assign smode     = item.frame_control[15:14];
    assign send_span = (smode != mfa_pkg::MODE_NONE) && !item.frame_control[6];
    assign hlen      = 5'd3
                     + ((dmode != mfa_pkg::MODE_NONE) ? 5'd2 : 5'd0)
                     + {1'b0, mfa_pkg::addr_bytes(dmode)}
                     + (send_span ? 5'd2 : 5'd0)
                     + {1'b0, mfa_pkg::addr_bytes(smode)};
    assign total     = {3'b000, hlen} + {1'b0, item.payload_length} + 8'd2;
    assign oversize  = total > 8'(MAX_FRAME_BYTES);

    always_comb
    begin
        remaining_next = remaining_reg;
        open_next      = open_reg;
        drop_next      = drop_reg;
        push           = 1'b0;
        job            = '0;

        if (accept)
        begin
            if (!item.kind)
            begin
                push           = 1'b1;
                job.is_hdr     = 1'b1;
                job.too_long   = oversize;
                job.fin        = (item.payload_length == 7'd0);
                job.bytes      = {item.source_address, item.source_pan, item.dest_address,
                                  item.dest_pan, item.sequence_number, item.frame_control};
                job.mask[2:0]  = 3'b111;
                job.mask[mfa_pkg::SLOT_DPAN +: 2]      = {2{dmode != mfa_pkg::MODE_NONE}};
                job.mask[mfa_pkg::SLOT_DADDR +: 2]     = {2{dmode[1]}};
                job.mask[mfa_pkg::SLOT_DADDR + 2 +: 6] = {6{dmode == mfa_pkg::MODE_EXT}};
                job.mask[mfa_pkg::SLOT_SPAN +: 2]      = {2{send_span}};
                job.mask[mfa_pkg::SLOT_SADDR +: 2]     = {2{smode[1]}};
                job.mask[mfa_pkg::SLOT_SADDR + 2 +: 6] = {6{smode == mfa_pkg::MODE_EXT}};
                remaining_next = item.payload_length;
                open_next      = !oversize && (item.payload_length != 7'd0);
                drop_next      = oversize && (item.payload_length != 7'd0);
            end
            else if (drop_reg)
            begin
                if (remaining_reg != 7'd0)
                begin
                    remaining_next = remaining_reg - 7'd1;
                end
                drop_next = (remaining_reg > 7'd1);
            end
            else if (open_reg && (remaining_reg != 7'd0))
            begin
                push            = 1'b1;
                job.fin         = (remaining_reg == 7'd1);
                job.bytes[0]    = item.payload_byte;
                remaining_next  = remaining_reg - 7'd1;
                open_next       = (remaining_reg != 7'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            open_reg      <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            open_reg      <= open_next;
            drop_reg      <= drop_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mfa_queue.sv @@
`default_nettype none

// Short job queue between the front and back ends.
module mfa_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  mfa_pkg::job_t    push_job,
    input  wire logic        pop,
    output logic             full,
    output logic             head_valid,
    output mfa_pkg::job_t    head_job
);

    localparam int DEPTH = mfa_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    mfa_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mfa_back.sv @@
`default_nettype none

`include "mac_frame_assembler_with_fcs_defines.svh"

// Executes jobs: walks the header slots, passes payload bytes, keeps the
// running CRC and appends the FCS into a registered output beat.
module mfa_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  mfa_pkg::job_t    head_job,
    output logic             pop,
    mfa_result_if.source     result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_HDR    = 2'd1;
    localparam logic [1:0] ST_FCS_LO = 2'd2;
    localparam logic [1:0] ST_FCS_HI = 2'd3;

    localparam int NS = mfa_pkg::HDR_SLOTS;

    logic [1:0]              state_reg, state_next;
    logic [NS-1:0]           mask_reg, mask_next;
    logic [NS-1:0][7:0]      data_reg, data_next;
    logic                    fin_reg, fin_next;
    logic [15:0]             crc_reg, crc_next;
    logic [6:0]              cnt_reg, cnt_next;

    logic                    ovalid_reg, ovalid_next;
    logic [7:0]              byte_reg, byte_next;
    logic                    last_reg, last_next;
    logic                    tl_reg, tl_next;
    logic [6:0]              flen_reg, flen_next;

    logic                        advance;
    logic [mfa_pkg::SLOT_W-1:0]  sel;
    logic [NS-1:0]               sel_hot;
    logic [NS-1:0]               mask_left;

    assign advance = !ovalid_reg || result.ready;

    assign result.valid        = ovalid_reg;
    assign result.frame_byte   = byte_reg;
    assign result.last         = last_reg;
    assign result.too_long     = tl_reg;
    assign result.frame_length = flen_reg;

    // Lowest enabled header slot goes out next.
    always_comb
    begin
        sel     = '0;
        sel_hot = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel     = mfa_pkg::SLOT_W'(i);
                sel_hot = NS'(1) << i;
            end
        end
    end

    assign mask_left = mask_reg & ~sel_hot;

    always_comb
    begin
        state_next  = state_reg;
        mask_next   = mask_reg;
        data_next   = data_reg;
        fin_next    = fin_reg;
        crc_next    = crc_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        tl_next     = tl_reg;
        flen_next   = flen_reg;
        pop         = 1'b0;

        if (advance)
        begin
            ovalid_next = 1'b0;
            byte_next   = 8'h00;
            last_next   = 1'b0;
            tl_next     = 1'b0;
            flen_next   = 7'd0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        pop = 1'b1;
                        if (head_job.is_hdr)
                        begin
                            crc_next = 16'h0000;
                            cnt_next = 7'd0;
                            if (head_job.too_long)
                            begin
                                ovalid_next = 1'b1;
                                last_next   = 1'b1;
                                tl_next     = 1'b1;
                            end
                            else
                            begin
                                mask_next  = head_job.mask;
                                data_next  = head_job.bytes;
                                fin_next   = head_job.fin;
                                state_next = ST_HDR;
                            end
                        end
                        else
                        begin
                            ovalid_next = 1'b1;
                            byte_next   = head_job.bytes[0];
                            crc_next    = mfa_pkg::crc_byte(crc_reg, head_job.bytes[0]);
                            cnt_next    = cnt_reg + 7'd1;
                            if (head_job.fin)
                            begin
                                state_next = ST_FCS_LO;
                            end
                        end
                    end
                end
                ST_HDR:
                begin
                    ovalid_next = 1'b1;
                    byte_next   = data_reg[sel];
                    crc_next    = mfa_pkg::crc_byte(crc_reg, data_reg[sel]);
                    cnt_next    = cnt_reg + 7'd1;
                    mask_next   = mask_left;
                    if (mask_left == '0)
                    begin
                        state_next = fin_reg ? ST_FCS_LO : ST_IDLE;
                    end
                end
                ST_FCS_LO:
                begin
                    ovalid_next = 1'b1;
                    byte_next   = crc_reg[7:0];
                    state_next  = ST_FCS_HI;
                end
                ST_FCS_HI:
                begin
                    ovalid_next = 1'b1;
                    byte_next   = crc_reg[15:8];
                    last_next   = 1'b1;
                    flen_next   = cnt_reg + mfa_pkg::FCS_BYTES;
                    state_next  = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        data_reg <= data_next;
        fin_reg  <= fin_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        tl_reg   <= tl_next;
        flen_reg <= flen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            crc_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            crc_reg    <= crc_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    `MFA_ASSERT_NOW(a_too_long_is_last, ovalid_reg && tl_reg, last_reg,
        "too_long beat without last")
    `MFA_ASSERT_NOW(a_hdr_has_slots, state_reg == ST_HDR, mask_reg != '0,
        "header walk with no slot left")
    `MFA_ASSERT_NEXT(a_fcs_order, (state_reg == ST_FCS_LO) && advance,
        state_reg == ST_FCS_HI, "FCS high byte did not follow low byte")
    `MFA_ASSERT_NOW(a_min_length, ovalid_reg && last_reg && !tl_reg, flen_reg >= 7'd5,
        "closing beat reports a frame shorter than the minimum")

endmodule

`default_nettype wire

@@ hw/rtl/mac_frame_assembler_with_fcs.sv @@
// Path: a payload beat's frame byte passes through the job queue and the output
// register; a header beat's first byte also passes the header slot registers.
// Throughput: one payload byte per cycle while the output is ready; a header job is
// taken first, then the slot walk sends one header byte per cycle while it is ready.
// The FCS adds two bytes, low then high, after the last byte of a frame.
// Reset: rst_n is asynchronous and clears all control state; no frame is open.
`default_nettype none

// IEEE 802.15.4 frame assembler with CRC-16 FCS.
//
// The front end accepts header and payload beats. It decides right away
// whether a frame is too long, which header slots are sent for the address
// modes in the frame control field, and whether a payload beat belongs to
// an open frame, is being dropped, or is a stray byte. Only beats that
// produce output become jobs in a two-entry queue.
//
// The back end drains that queue. A header job is walked slot by slot, one
// byte per cycle while the output register can advance, always taking the
// lowest enabled slot so that the fields come out little-endian in frame
// order. A payload job loads its byte into the output register when taken.
// The running CRC (reflected 0x8408, zero seed) covers each header and
// payload byte and is appended low byte first, with last and the total
// length on the final FCS beat. The back end stalls while its output waits.
//
// A header arriving while a frame is open simply starts a new frame; the
// back end clears its CRC and byte count when it takes the header job.
module mac_frame_assembler_with_fcs #(
    parameter int MAX_FRAME_BYTES = mfa_pkg::FRAME_MAX_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mfa_item_if.sink     item,
    mfa_result_if.source result
);

    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;
    mfa_pkg::job_t  push_job;
    mfa_pkg::job_t  head_job;

    // Classify accepted beats and build jobs.
    mfa_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    // Decouples front and back so each can stall independently.
    mfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Serialize header slots, payload bytes and the FCS.
    mfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
